// File: rtl/odo_pkg.sv
// Shared types, constants and table helpers for the wheel odometry block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package odo_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CNT_W         = 32;
  localparam int POS_W         = 48;
  localparam int HEAD_OUT_W    = 32;
  localparam int CFG_W         = 16;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 3;
  localparam logic [CFG_W-1:0] MM_RESET  = 16'd44761;
  localparam logic [CFG_W-1:0] DEG_RESET = 16'd16253;

  localparam int DEG_FULL    = 360;
  localparam int DEG_HALF    = 180;
  localparam int DEG_THREE_Q = 270;
  localparam int DEG_QUARTER = 90;
  localparam int DEG_W       = 9;
  localparam int DIGIT_BITS  = 4;

  localparam int TAB_LEN   = 91;
  localparam int TAB_IW    = 7;
  localparam longint TAB_SCALE = 64'd10000000;

  localparam int unsigned QSINE_RAW [TAB_LEN] = '{
    0, 174436, 348818, 523094, 697212, 871117, 1044760, 1218080,
    1391030, 1563560, 1735610, 1907130, 2078080, 2248390, 2418020,
    2586910, 2755010, 2922280, 3088660, 3254090, 3418540, 3581940,
    3744260, 3905440, 4065430, 4224180, 4381640, 4537780, 4692530,
    4845850, 4997700, 5148030, 5296790, 5443940, 5589430, 5733230,
    5875280, 6015540, 6153960, 6290520, 6425160, 6557850, 6688540,
    6817200, 6943780, 7068250, 7190570, 7310700, 7428610, 7544250,
    7657600, 7768620, 7877270, 7983530, 8087360, 8188730, 8287600,
    8383960, 8477760, 8568980, 8657600, 8743580, 8826900, 8907530,
    8985460, 9060650, 9133080, 9202730, 9269580, 9333610, 9394810,
    9453140, 9508590, 9561160, 9610810, 9657540, 9701330, 9742170,
    9780040, 9814940, 9846850, 9875760, 9901670, 9924560, 9944440,
    9961290, 9975110, 9985890, 9993630, 9998340, 10000000
  };

  typedef enum logic {
    REG_MM,
    REG_DEG
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_HEAD,
    ST_MOD,
    ST_ANG,
    ST_LOOK,
    ST_INTERP,
    ST_PROD,
    ST_SUM,
    ST_ACC,
    ST_DONE
  } odo_state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic mul;
    logic head;
    logic mod_step;
    logic ang;
    logic look;
    logic interp;
    logic prod;
    logic sum;
    logic acc;
    logic out_load;
  } odo_cmd_t;

  typedef struct packed {
    logic mod_last;
  } odo_stat_t;

  typedef struct packed {
    logic              neg;
    logic [TAB_IW-1:0] idx;
  } fold_t;

  function automatic longint sine_entry(int idx, int frac);
    return ((longint'(QSINE_RAW[idx]) << frac) + TAB_SCALE / 2) / TAB_SCALE;
  endfunction

  function automatic int wrap_rem(int w);
    int r;
    r = 1;
    for (int i = 0; i < w; i++) begin
      r = r * 2;
      if (r >= DEG_FULL) begin
        r = r - DEG_FULL;
      end
    end
    return r;
  endfunction

  function automatic fold_t sine_fold(logic [DEG_W-1:0] d);
    fold_t f;
    f.neg = 1'b0;
    f.idx = '0;
    if (d <= DEG_W'(DEG_QUARTER)) begin
      f.idx = TAB_IW'(d);
    end else if (d <= DEG_W'(DEG_HALF)) begin
      f.idx = TAB_IW'(DEG_W'(DEG_HALF) - d);
    end else if (d <= DEG_W'(DEG_THREE_Q)) begin
      f.neg = 1'b1;
      f.idx = TAB_IW'(d - DEG_W'(DEG_HALF));
    end else begin
      f.neg = 1'b1;
      f.idx = TAB_IW'(DEG_W'(DEG_FULL) - d);
    end
    return f;
  endfunction

endpackage

// File: rtl/odo_in_if.sv
// Input channel of the odometry block: valid/ready plus one update or clear item.
// Depends on odo_pkg for field widths.
interface odo_in_if import odo_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic signed [CNT_W-1:0] left_count;
  logic signed [CNT_W-1:0] right_count;

  modport source(output valid, operation, left_count, right_count, input ready);
  modport sink(input valid, operation, left_count, right_count, output ready);
endinterface

// File: rtl/odo_out_if.sv
// Result channel of the odometry block: valid/ready plus position and heading.
// Depends on odo_pkg for field widths.
interface odo_out_if import odo_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [POS_W-1:0]      pos_x;
  logic signed [POS_W-1:0]      pos_y;
  logic signed [HEAD_OUT_W-1:0] heading_deg;

  modport source(output valid, pos_x, pos_y, heading_deg, input ready);
  modport sink(input valid, pos_x, pos_y, heading_deg, output ready);
endinterface

// File: rtl/differential_drive_odometry.sv
// Top level of the differential-drive odometry block: configuration registers,
// controller and datapath. Depends on odo_pkg, odo_in_if, odo_out_if, odo_ctrl
// and odo_datapath.
//
//   Port group   Direction  Handshake          Carries
//   in_chan      sink       valid / ready      operation, left_count, right_count
//   out_chan     source     valid / ready      pos_x, pos_y, heading_deg
//   APB          slave      psel / penable     mm_per_count_q16, deg_per_count_q16
//
// An update runs through the states MUL, HEAD, MOD, ANG, LOOK, INTERP, PROD, SUM, ACC
// and DONE from its transfer to its result; the modulo-360 reduction of the heading,
// four bits a cycle, and the chain of registered multiplies set its length.
// Reset is synchronous and active low; it zeroes position, heading and kept counts.
// A new item is taken while the previous result still waits in the output register;
// a finished item waits for that register to free before the next transfer.
module differential_drive_odometry import odo_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  odo_in_if.sink            in_chan,
  odo_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] mm_r, deg_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  odo_cmd_t         cmd;
  odo_stat_t        stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_r  <= MM_RESET;
      deg_r <= DEG_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MM:  mm_r  <= pwdata[CFG_W-1:0];
        REG_DEG: deg_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MM:  prdata = DATA_W'(mm_r);
      REG_DEG: prdata = DATA_W'(deg_r);
      default: prdata = '0;
    endcase
  end

  odo_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_chan.ready),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .cmd          (cmd),
    .stat         (stat)
  );

  odo_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .mm_per_count  (mm_r),
    .deg_per_count (deg_r),
    .left_count    (in_chan.left_count),
    .right_count   (in_chan.right_count),
    .pos_x         (out_chan.pos_x),
    .pos_y         (out_chan.pos_y),
    .heading_deg   (out_chan.heading_deg)
  );

endmodule

// File: rtl/odo_ctrl.sv
// Sequencing state machine for the odometry block and the result valid flag.
// Depends on odo_pkg for the state, command and status types.
module odo_ctrl import odo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_operation,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output odo_cmd_t  cmd,
  input  odo_stat_t stat
);

  odo_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation) begin
            cmd.clear = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_HEAD;
      end
      ST_HEAD: begin
        cmd.head  = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = ST_ANG;
        end
      end
      ST_ANG: begin
        cmd.ang   = 1'b1;
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_nxt  = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/odo_datapath.sv
// Odometry datapath: deltas, heading and position accumulators, angle reduction,
// interpolated sine table and scaled position steps. Depends on odo_pkg.
module odo_datapath import odo_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  odo_cmd_t                     cmd,
  output odo_stat_t                    stat,
  input  logic        [CFG_W-1:0]      mm_per_count,
  input  logic        [CFG_W-1:0]      deg_per_count,
  input  logic signed [CNT_W-1:0]      left_count,
  input  logic signed [CNT_W-1:0]      right_count,
  output logic signed [POS_W-1:0]      pos_x,
  output logic signed [POS_W-1:0]      pos_y,
  output logic signed [HEAD_OUT_W-1:0] heading_deg
);

  localparam int F        = FRAC_BITS;
  localparam int IW       = POS_W - F;
  localparam int NSTEP    = (IW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PADW     = NSTEP * DIGIT_BITS;
  localparam int CW       = $clog2(NSTEP);
  localparam int WRAP_R   = wrap_rem(IW);
  localparam int TW       = F + 2;
  localparam int PW       = CNT_W + 2 + CFG_W;
  localparam int SPL      = PW / 2;
  localparam int HW       = PW - SPL;
  localparam int LW       = SPL + 1 + TW;
  localparam int MHW      = HW + TW;
  localparam int FW       = PW + TW;
  localparam int IPW      = 2 * F + 4;
  localparam int LANE_COS = 0;
  localparam int LANE_SIN = 1;

  logic [CNT_W-1:0]        prev_l_r, prev_r_r;
  logic signed [CNT_W-1:0] dl_r, dr_r;
  logic [POS_W-1:0]        turn_r;
  logic signed [PW-1:0]    p_r;
  logic [POS_W-1:0]        head_r, x_r, y_r;
  logic [PADW-1:0]         mod_sh_r;
  logic [F-1:0]            frac_r;
  logic                    neg_r;
  logic [DEG_W-1:0]        rem_r;
  logic [CW-1:0]           cnt_r;
  logic [DEG_W-1:0]        dsin_r, dcos_r;
  logic signed [TW-1:0]    s0_r [2];
  logic signed [TW-1:0]    s1_r [2];
  logic signed [TW-1:0]    trig_r [2];
  logic signed [LW-1:0]    mlo_r [2];
  logic signed [MHW-1:0]   mhi_r [2];
  logic [POS_W-1:0]        step_r [2];
  logic [POS_W-1:0]        out_x_r, out_y_r;
  logic [HEAD_OUT_W-1:0]   out_h_r;

  logic signed [CNT_W:0]   d_diff, d_sum;
  logic signed [PW-1:0]    turn_full, p_full;
  logic [POS_W-1:0]        head_nxt;
  logic [DEG_W:0]          rem_step;
  logic [DEG_W-1:0]        d_base, d_cos;
  logic [F:0]              tab_w [TAB_LEN];
  logic [DEG_W-1:0]        lk_ang [2];
  logic [DEG_W-1:0]        lk_ang1 [2];
  fold_t                   fd0 [2];
  fold_t                   fd1 [2];
  logic signed [TW-1:0]    lk_s0 [2];
  logic signed [TW-1:0]    lk_s1 [2];
  logic signed [TW:0]      ip_d [2];
  logic signed [IPW-1:0]   ip_prod [2];
  logic signed [TW-1:0]    trig_w [2];
  logic signed [LW-1:0]    mlo_w [2];
  logic signed [MHW-1:0]   mhi_w [2];
  logic signed [FW-1:0]    full_w [2];
  logic signed [IW-1:0]    whole_w;

  for (genvar g = 0; g < TAB_LEN; g++) begin : g_tab
    localparam longint TQ = sine_entry(g, F);
    assign tab_w[g] = (F + 1)'(TQ);
  end

  assign d_diff    = (CNT_W + 1)'(dr_r) - (CNT_W + 1)'(dl_r);
  assign d_sum     = (CNT_W + 1)'(dr_r) + (CNT_W + 1)'(dl_r);
  assign turn_full = d_diff * $signed({1'b0, deg_per_count});
  assign p_full    = d_sum * $signed({1'b0, mm_per_count});
  assign head_nxt  = head_r + turn_r;

  always_comb begin
    rem_step = {1'b0, rem_r};
    for (int k = 0; k < DIGIT_BITS; k++) begin
      rem_step = {rem_step[DEG_W-1:0], mod_sh_r[PADW-1-k]};
      if (rem_step >= (DEG_W + 1)'(DEG_FULL)) begin
        rem_step = rem_step - (DEG_W + 1)'(DEG_FULL);
      end
    end
  end

  assign stat.mod_last = (cnt_r == CW'(NSTEP - 1));

  always_comb begin
    d_base = rem_r;
    if (neg_r) begin
      if (rem_r >= DEG_W'(WRAP_R)) begin
        d_base = rem_r - DEG_W'(WRAP_R);
      end else begin
        d_base = rem_r + DEG_W'(DEG_FULL - WRAP_R);
      end
    end
    if (d_base >= DEG_W'(DEG_FULL - DEG_QUARTER)) begin
      d_cos = d_base - DEG_W'(DEG_FULL - DEG_QUARTER);
    end else begin
      d_cos = d_base + DEG_W'(DEG_QUARTER);
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lk_ang[i]  = (i == LANE_SIN) ? dsin_r : dcos_r;
      lk_ang1[i] = lk_ang[i] + 1'b1;
      fd0[i]     = sine_fold(lk_ang[i]);
      fd1[i]     = sine_fold(lk_ang1[i]);
      lk_s0[i]   = fd0[i].neg ? -$signed({1'b0, tab_w[fd0[i].idx]})
                              : $signed({1'b0, tab_w[fd0[i].idx]});
      lk_s1[i]   = fd1[i].neg ? -$signed({1'b0, tab_w[fd1[i].idx]})
                              : $signed({1'b0, tab_w[fd1[i].idx]});
      ip_d[i]    = (TW + 1)'(s1_r[i]) - (TW + 1)'(s0_r[i]);
      ip_prod[i] = $signed({1'b0, frac_r}) * ip_d[i];
      trig_w[i]  = s0_r[i] + TW'(ip_prod[i] >>> F);
      mlo_w[i]   = $signed({1'b0, p_r[SPL-1:0]}) * trig_r[i];
      mhi_w[i]   = $signed(p_r[PW-1:SPL]) * trig_r[i];
      full_w[i]  = (FW'(mhi_r[i]) <<< SPL) + FW'(mlo_r[i]);
    end
  end

  assign whole_w = $signed(head_r[POS_W-1:F])
                 + IW'(head_r[POS_W-1] && (|head_r[F-1:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_l_r <= '0;
      prev_r_r <= '0;
      head_r   <= '0;
      x_r      <= '0;
      y_r      <= '0;
    end else begin
      if (cmd.clear) begin
        prev_l_r <= '0;
        prev_r_r <= '0;
      end else if (cmd.capture) begin
        prev_l_r <= left_count;
        prev_r_r <= right_count;
      end
      if (cmd.head) begin
        head_r <= head_nxt;
      end
      if (cmd.acc) begin
        x_r <= x_r + step_r[LANE_COS];
        y_r <= y_r + step_r[LANE_SIN];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dl_r <= left_count - prev_l_r;
      dr_r <= right_count - prev_r_r;
    end
    if (cmd.mul) begin
      turn_r <= turn_full[POS_W-1:0];
      p_r    <= p_full;
    end
    if (cmd.head) begin
      mod_sh_r <= PADW'(head_nxt[POS_W-1:F]);
      frac_r   <= head_nxt[F-1:0];
      neg_r    <= head_nxt[POS_W-1];
      rem_r    <= '0;
      cnt_r    <= '0;
    end else if (cmd.mod_step) begin
      mod_sh_r <= mod_sh_r << DIGIT_BITS;
      rem_r    <= rem_step[DEG_W-1:0];
      cnt_r    <= cnt_r + 1'b1;
    end
    if (cmd.ang) begin
      dsin_r <= d_base;
      dcos_r <= d_cos;
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd.look) begin
        s0_r[i] <= lk_s0[i];
        s1_r[i] <= lk_s1[i];
      end
      if (cmd.interp) begin
        trig_r[i] <= trig_w[i];
      end
      if (cmd.prod) begin
        mlo_r[i] <= mlo_w[i];
        mhi_r[i] <= mhi_w[i];
      end
      if (cmd.sum) begin
        step_r[i] <= full_w[i][F+1 +: POS_W];
      end
    end
    if (cmd.out_load) begin
      out_x_r <= x_r;
      out_y_r <= y_r;
      out_h_r <= HEAD_OUT_W'(whole_w);
    end
  end

  assign pos_x       = out_x_r;
  assign pos_y       = out_y_r;
  assign heading_deg = out_h_r;

endmodule
